// ----- rtl/grc_pkg.sv -----
// Shared types, constants and tables for the grid ray caster.
`timescale 1ns / 1ps
package grc_pkg;

  localparam int CORDIC_ITERS = 14;
  localparam int CORDIC_W     = 18;
  localparam int CORDIC_X0    = 9949;
  localparam int A_W          = 21;
  localparam int B_W          = 38;
  localparam int COORD_W      = 17;
  localparam int MUL_W        = 19;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int UNIT_W       = 36;
  localparam int UNIT_CNT_W   = 6;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_rsp_t;

  // Arctangent of 2^-i in binary angle units.
  function automatic logic [CORDIC_W-1:0] atan_units(input logic [3:0] i);
    logic [CORDIC_W-1:0] v;
    case (i)
      4'd0:    v = CORDIC_W'(8192);
      4'd1:    v = CORDIC_W'(4836);
      4'd2:    v = CORDIC_W'(2555);
      4'd3:    v = CORDIC_W'(1297);
      4'd4:    v = CORDIC_W'(651);
      4'd5:    v = CORDIC_W'(326);
      4'd6:    v = CORDIC_W'(163);
      4'd7:    v = CORDIC_W'(81);
      4'd8:    v = CORDIC_W'(41);
      4'd9:    v = CORDIC_W'(20);
      4'd10:   v = CORDIC_W'(10);
      4'd11:   v = CORDIC_W'(5);
      4'd12:   v = CORDIC_W'(3);
      4'd13:   v = CORDIC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/grc_if.sv -----
// Valid/ready channel interfaces for viewer items and ray results.
`timescale 1ns / 1ps
interface grc_in_if;
  logic        valid;
  logic        ready;
  logic [14:0] viewer_x;
  logic [14:0] viewer_y;
  logic [15:0] heading;
  modport source (output valid, viewer_x, viewer_y, heading, input ready);
  modport sink   (input valid, viewer_x, viewer_y, heading, output ready);
endinterface

interface grc_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  ray_number;
  logic [14:0] hit_x;
  logic [14:0] hit_y;
  logic [15:0] range;
  logic        from_vertical;
  logic        found_wall;
  logic        last_ray;
  modport source (output valid, ray_number, hit_x, hit_y, range, from_vertical, found_wall,
                  last_ray, input ready);
  modport sink   (input valid, ray_number, hit_x, hit_y, range, from_vertical, found_wall,
                  last_ray, output ready);
endinterface

// ----- rtl/grc_iter_unit.sv -----
// Shared iterative unit: restoring divide and integer square root, one bit per cycle.
`timescale 1ns / 1ps
module grc_iter_unit import grc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  unit_req_t         req,
  input  logic [UNIT_W-1:0] operand_a,
  input  logic [UNIT_W-1:0] operand_b,
  output unit_rsp_t         rsp,
  output logic [UNIT_W-1:0] result
);

  localparam int DIV_ITERS  = UNIT_W;
  localparam int SQRT_ITERS = UNIT_W / 2;

  logic                  busy_r;
  logic                  done_r;
  unit_op_t              op_r;
  logic [UNIT_CNT_W-1:0] cnt_r;
  logic [UNIT_W-1:0]     acc_r;
  logic [UNIT_W-1:0]     wrk_r;
  logic [UNIT_W-1:0]     bit_r;
  logic [UNIT_W-1:0]     div_r;

  logic [UNIT_W-1:0] trial_a;
  logic [UNIT_W-1:0] trial_b;
  logic [UNIT_W-1:0] diff;
  logic              ge;
  logic              last;

  // One compare-and-subtract serves both operations.
  always_comb begin
    if (op_r == OP_DIV) begin
      trial_a = {acc_r[UNIT_W-2:0], wrk_r[UNIT_W-1]};
      trial_b = div_r;
      last    = (cnt_r == UNIT_CNT_W'(DIV_ITERS - 1));
    end else begin
      trial_a = acc_r;
      trial_b = wrk_r + bit_r;
      last    = (cnt_r == UNIT_CNT_W'(SQRT_ITERS - 1));
    end
    ge   = (trial_a >= trial_b);
    diff = trial_a - trial_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        if (req.op == OP_DIV) begin
          acc_r <= '0;
          wrk_r <= operand_a;
          div_r <= operand_b;
        end else begin
          acc_r <= operand_a;
          wrk_r <= '0;
          bit_r <= UNIT_W'(1) << (UNIT_W - 2);
        end
      end else if (busy_r) begin
        acc_r <= ge ? diff : trial_a;
        if (op_r == OP_DIV) begin
          wrk_r <= {wrk_r[UNIT_W-2:0], ge};
        end else begin
          wrk_r <= ge ? ((wrk_r >> 1) + bit_r) : (wrk_r >> 1);
          bit_r <= bit_r >> 2;
        end
        cnt_r <= cnt_r + UNIT_CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign result   = wrk_r;

endmodule

// ----- rtl/grid_ray_caster.sv -----
// Top level of the grid ray caster: ray sequencer, CORDIC, grid walk and result register.
//
// Usage: a viewer item (viewer_x, viewer_y in Q7.8 pixels, heading as a binary angle)
// is transferred on in_ch when valid and ready are both high. The block then casts
// RAY_COUNT rays, sweeping from heading - (RAY_COUNT/2)*ray_step upward, and delivers
// one result per ray on out_ch in ray order; last_ray marks the final one.
// in_ch.ready is high only while no sweep is running, so items are taken one at a time.
// Per ray: the CORDIC rotation, then for each of the two gridline passes a setup step
// and up to MAX_STEPS crossings; a crossing inside the map needs one multiply and a
// 36-step division in the shared divide/square-root unit, one outside needs neither.
// The distance takes squaring, a select step and the square root, and then the result
// register is written. Results sit in an output register: if the receiver stalls, the
// sweep waits before the next ray is written there, and nothing is lost. Configuration
// (wall_mask at index 0, ray_step at index 1) is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while idle, which the block does not enforce.
// A synchronous active-low reset returns to idle, drops out_ch.valid and restores the
// default wall map and ray step.
`timescale 1ns / 1ps
module grid_ray_caster import grc_pkg::*; #(
  parameter int RAY_COUNT  = 60,
  parameter int MAX_STEPS  = 8,
  parameter int GRID_DIM   = 8,
  parameter int CELL_SHIFT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [63:0]       cfg_data,
  grc_in_if.sink            in_ch,
  grc_out_if.source         out_ch
);

  localparam int POS_SHIFT = 8 + CELL_SHIFT;
  localparam int RAY_W     = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;
  localparam int STEP_W    = $clog2(MAX_STEPS + 1);
  localparam int GRID_W    = $clog2(GRID_DIM);
  localparam int HALF_SPAN = RAY_COUNT / 2;

  localparam logic        CFG_WALL_MASK  = 1'b0;
  localparam logic [63:0] WALL_RESET     = 64'd18411262290262590975;
  localparam logic [12:0] RAY_STEP_RESET = 13'd182;

  localparam logic [15:0] ANG_ZERO    = 16'd0;
  localparam logic [15:0] ANG_QUARTER = 16'd16384;
  localparam logic [15:0] ANG_HALF    = 16'd32768;
  localparam logic [15:0] ANG_3Q      = 16'd49152;

  localparam logic signed [A_W-1:0] CELL_A  = A_W'(1 << POS_SHIFT);
  localparam logic signed [A_W-1:0] LIMIT_A = A_W'(GRID_DIM << POS_SHIFT);
  localparam logic signed [B_W-1:0] LIMIT_B = B_W'(GRID_DIM << POS_SHIFT);

  typedef enum logic [3:0] {
    S_IDLE, S_CINIT, S_CORDIC, S_CFIN, S_WSTART, S_STEP, S_DIVGO, S_DIV,
    S_CHECK, S_SQ, S_SEL, S_SQRT, S_EMIT
  } state_t;

  state_t state_r;

  logic [63:0]      wall_mask_r;
  logic [12:0]      ray_step_r;
  logic [14:0]      px_r, py_r;
  logic [15:0]      ang_r;
  logic [RAY_W-1:0] ray_r;

  // CORDIC registers.
  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic                       flip_r;
  logic [3:0]                 it_r;
  logic signed [CORDIC_W-1:0] c_r, s_r;

  // Grid walk registers.
  logic                      pass_r;
  logic                      fwd_r;
  logic signed [A_W-1:0]     a_r;
  logic [STEP_W-1:0]         k_r;
  logic [CORDIC_W-1:0]       dmag_r;
  logic                      qneg_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      hh_r, vh_r;
  logic [COORD_W-1:0]        hx_r, hy_r, vx_r, vy_r;
  logic [UNIT_W-1:0]         dh_r, dv_r;
  logic [2:0]                sq_cnt_r;
  logic [COORD_W-1:0]        ox_r, oy_r;
  logic                      vert_r, found_r;
  logic [15:0]               rng_r;

  // Result register.
  logic        out_valid_r;
  logic [5:0]  o_ray_r;
  logic [14:0] o_hx_r, o_hy_r;
  logic [15:0] o_rng_r;
  logic        o_vert_r, o_found_r, o_last_r;

  // Shared unit connections.
  unit_req_t         unit_req;
  unit_rsp_t         unit_rsp;
  logic [UNIT_W-1:0] unit_a;
  logic [UNIT_W-1:0] unit_b;
  logic [UNIT_W-1:0] unit_res;

  grc_iter_unit u_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (unit_req),
    .operand_a (unit_a),
    .operand_b (unit_b),
    .rsp       (unit_rsp),
    .result    (unit_res)
  );

  // Sweep start angle.
  logic [15:0] span_off;
  assign span_off = 16'(HALF_SPAN) * {3'b0, ray_step_r};

  // A finished ray moves into the result register when that register is free.
  logic emit_go;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);

  // CORDIC step: one micro-rotation per cycle.
  logic signed [CORDIC_W-1:0] xs, ys, atan_s, z0, ang_s;
  logic                       flip0;
  always_comb begin
    xs     = cx_r >>> it_r;
    ys     = cy_r >>> it_r;
    atan_s = $signed(atan_units(it_r));
    ang_s  = $signed({2'b0, ang_r});
    flip0  = (ang_r >= ANG_QUARTER) && (ang_r < ANG_3Q);
    if (flip0) begin
      z0 = ang_s - CORDIC_W'(32768);
    end else if (ang_r[15]) begin
      z0 = ang_s - CORDIC_W'(65536);
    end else begin
      z0 = ang_s;
    end
  end

  // Pass selection: the horizontal pass walks y crossings, the vertical pass x crossings.
  logic [14:0]                pa, pb, pa_cell;
  logic signed [CORDIC_W-1:0] num, den;
  logic [CORDIC_W-1:0]        den_abs;
  logic                       pass_en, fwd0;
  logic signed [A_W-1:0]      a_init, a_step, diff_full;
  logic                       a_out;
  always_comb begin
    pa      = pass_r ? px_r : py_r;
    pb      = pass_r ? py_r : px_r;
    num     = pass_r ? s_r : c_r;
    den     = pass_r ? c_r : s_r;
    pass_en = pass_r ? ((ang_r != ANG_QUARTER) && (ang_r != ANG_3Q))
                     : ((ang_r != ANG_ZERO) && (ang_r != ANG_HALF));
    fwd0    = pass_r ? !((ang_r > ANG_QUARTER) && (ang_r < ANG_3Q)) : (ang_r < ANG_HALF);
    pa_cell = pa >> POS_SHIFT;
    a_init  = fwd0 ? $signed((A_W'(pa_cell) + A_W'(1)) << POS_SHIFT)
                   : $signed((A_W'(pa_cell) << POS_SHIFT) - A_W'(1));
    den_abs = den[CORDIC_W-1] ? CORDIC_W'(-den) : CORDIC_W'(den);
    a_step  = fwd_r ? (a_r + CELL_A) : (a_r - CELL_A);
    a_out   = (a_r < 0) || (a_r >= LIMIT_A);
    diff_full = a_r - $signed({{(A_W-15){1'b0}}, pa});
  end

  // Shared multiplier operands: the slope product while walking, squares for the distance.
  logic signed [MUL_W-1:0] mul_a, mul_b, sq_op;
  always_comb begin
    case (sq_cnt_r)
      3'd0:    sq_op = $signed({{(MUL_W-COORD_W){1'b0}}, hx_r}) -
                       $signed({{(MUL_W-15){1'b0}}, px_r});
      3'd1:    sq_op = $signed({{(MUL_W-COORD_W){1'b0}}, hy_r}) -
                       $signed({{(MUL_W-15){1'b0}}, py_r});
      3'd2:    sq_op = $signed({{(MUL_W-COORD_W){1'b0}}, vx_r}) -
                       $signed({{(MUL_W-15){1'b0}}, px_r});
      3'd3:    sq_op = $signed({{(MUL_W-COORD_W){1'b0}}, vy_r}) -
                       $signed({{(MUL_W-15){1'b0}}, py_r});
      default: sq_op = '0;
    endcase
    if (state_r == S_SQ) begin
      mul_a = sq_op;
      mul_b = sq_op;
    end else begin
      mul_a = diff_full[MUL_W-1:0];
      mul_b = MUL_W'(num);
    end
  end

  // Crossing check: the other coordinate, then the wall bit of the cell.
  logic [PROD_W-1:0]     prod_abs;
  logic signed [B_W-1:0] q_s, b_val, xw, yw;
  logic                  b_in, is_wall;
  logic [GRID_W-1:0]     col, row;
  logic [5:0]            idx;
  logic                  take_h;
  always_comb begin
    prod_abs = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
    q_s      = $signed(B_W'(unit_res));
    b_val    = $signed(B_W'(pb)) + (qneg_r ? -q_s : q_s);
    b_in     = (b_val >= 0) && (b_val < LIMIT_B);
    xw       = pass_r ? B_W'(a_r) : b_val;
    yw       = pass_r ? b_val : B_W'(a_r);
    col      = xw[POS_SHIFT +: GRID_W];
    row      = yw[POS_SHIFT +: GRID_W];
    idx      = 6'(row) * 6'(GRID_DIM) + 6'(col);
    // The corner cell at index zero never counts as a wall.
    is_wall  = b_in && (idx != 6'd0) && wall_mask_r[idx];
    take_h   = hh_r && (!vh_r || (dh_r < dv_r));
  end

  always_comb begin
    unit_req.start = (state_r == S_DIVGO) || ((state_r == S_SEL) && (hh_r || vh_r));
    unit_req.op    = (state_r == S_SEL) ? OP_SQRT : OP_DIV;
    unit_a         = (state_r == S_SEL) ? (take_h ? dh_r : dv_r) : prod_abs[UNIT_W-1:0];
    unit_b         = UNIT_W'(dmag_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      wall_mask_r <= WALL_RESET;
      ray_step_r  <= RAY_STEP_RESET;
    end else begin
      prod_r <= mul_a * mul_b;
      if (cfg_we) begin
        if (cfg_index == CFG_WALL_MASK) begin
          wall_mask_r <= cfg_data;
        end else begin
          ray_step_r <= cfg_data[12:0];
        end
      end
      if (out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            px_r    <= in_ch.viewer_x;
            py_r    <= in_ch.viewer_y;
            ang_r   <= in_ch.heading - span_off;
            ray_r   <= '0;
            state_r <= S_CINIT;
          end
        end
        S_CINIT: begin
          cx_r    <= CORDIC_W'(CORDIC_X0);
          cy_r    <= '0;
          cz_r    <= z0;
          flip_r  <= flip0;
          it_r    <= '0;
          hh_r    <= 1'b0;
          vh_r    <= 1'b0;
          pass_r  <= 1'b0;
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!cz_r[CORDIC_W-1]) begin
            cx_r <= cx_r - ys;
            cy_r <= cy_r + xs;
            cz_r <= cz_r - atan_s;
          end else begin
            cx_r <= cx_r + ys;
            cy_r <= cy_r - xs;
            cz_r <= cz_r + atan_s;
          end
          it_r <= it_r + 4'd1;
          if (it_r == 4'(CORDIC_ITERS - 1)) begin
            state_r <= S_CFIN;
          end
        end
        S_CFIN: begin
          c_r     <= flip_r ? -cx_r : cx_r;
          s_r     <= flip_r ? -cy_r : cy_r;
          state_r <= S_WSTART;
        end
        S_WSTART: begin
          if (pass_en) begin
            fwd_r   <= fwd0;
            a_r     <= a_init;
            k_r     <= '0;
            dmag_r  <= (den_abs == '0) ? CORDIC_W'(1) : den_abs;
            state_r <= S_STEP;
          end else if (!pass_r) begin
            pass_r  <= 1'b1;
            state_r <= S_WSTART;
          end else begin
            sq_cnt_r <= '0;
            state_r  <= S_SQ;
          end
        end
        S_STEP: begin
          if (k_r == STEP_W'(MAX_STEPS)) begin
            if (!pass_r) begin
              pass_r  <= 1'b1;
              state_r <= S_WSTART;
            end else begin
              sq_cnt_r <= '0;
              state_r  <= S_SQ;
            end
          end else if (a_out) begin
            // A crossing outside the map is a miss without any arithmetic.
            a_r <= a_step;
            k_r <= k_r + STEP_W'(1);
          end else begin
            state_r <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          qneg_r  <= prod_r[PROD_W-1] ^ !fwd_r;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (unit_rsp.done) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (is_wall) begin
            if (!pass_r) begin
              hh_r    <= 1'b1;
              hx_r    <= COORD_W'(b_val);
              hy_r    <= COORD_W'(a_r);
              pass_r  <= 1'b1;
              state_r <= S_WSTART;
            end else begin
              vh_r     <= 1'b1;
              vx_r     <= COORD_W'(a_r);
              vy_r     <= COORD_W'(b_val);
              sq_cnt_r <= '0;
              state_r  <= S_SQ;
            end
          end else begin
            a_r     <= a_step;
            k_r     <= k_r + STEP_W'(1);
            state_r <= S_STEP;
          end
        end
        S_SQ: begin
          // The product of the previous cycle's operand lands here.
          case (sq_cnt_r)
            3'd1:    dh_r <= UNIT_W'(prod_r);
            3'd2:    dh_r <= dh_r + UNIT_W'(prod_r);
            3'd3:    dv_r <= UNIT_W'(prod_r);
            3'd4:    dv_r <= dv_r + UNIT_W'(prod_r);
            default: ;
          endcase
          sq_cnt_r <= sq_cnt_r + 3'd1;
          if (sq_cnt_r == 3'd4) begin
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          if (take_h) begin
            ox_r    <= hx_r;
            oy_r    <= hy_r;
            vert_r  <= 1'b0;
            found_r <= 1'b1;
            state_r <= S_SQRT;
          end else if (vh_r) begin
            ox_r    <= vx_r;
            oy_r    <= vy_r;
            vert_r  <= 1'b1;
            found_r <= 1'b1;
            state_r <= S_SQRT;
          end else begin
            ox_r    <= COORD_W'(px_r);
            oy_r    <= COORD_W'(py_r);
            vert_r  <= 1'b0;
            found_r <= 1'b0;
            rng_r   <= 16'hFFFF;
            state_r <= S_EMIT;
          end
        end
        S_SQRT: begin
          if (unit_rsp.done) begin
            rng_r   <= (unit_res > UNIT_W'(16'hFFFF)) ? 16'hFFFF : unit_res[15:0];
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            o_ray_r     <= 6'(ray_r);
            o_hx_r      <= ox_r[14:0];
            o_hy_r      <= oy_r[14:0];
            o_rng_r     <= rng_r;
            o_vert_r    <= vert_r;
            o_found_r   <= found_r;
            o_last_r    <= (ray_r == RAY_W'(RAY_COUNT - 1));
            if (ray_r == RAY_W'(RAY_COUNT - 1)) begin
              state_r <= S_IDLE;
            end else begin
              ray_r   <= ray_r + RAY_W'(1);
              ang_r   <= ang_r + {3'b0, ray_step_r};
              state_r <= S_CINIT;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.ray_number    = o_ray_r;
  assign out_ch.hit_x         = o_hx_r;
  assign out_ch.hit_y         = o_hy_r;
  assign out_ch.range         = o_rng_r;
  assign out_ch.from_vertical = o_vert_r;
  assign out_ch.found_wall    = o_found_r;
  assign out_ch.last_ray      = o_last_r;

`ifndef SYNTHESIS
  a_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    unit_rsp.busy |-> (state_r == S_DIV || state_r == S_SQRT))
    else $error("shared unit busy outside a wait state");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_CHECK) |-> (k_r <= STEP_W'(MAX_STEPS)))
    else $error("walk step count past limit");
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_ray == (out_ch.ray_number == 6'(RAY_COUNT - 1))))
    else $error("last_ray does not match ray number");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_CINIT && ray_r == '0))
    else $error("accepted item did not start a sweep");
`endif

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the grid ray caster: directed sweeps, map extremes and random views.
`timescale 1ns / 1ps
module tb_top;

  // Register indexes on the configuration port.
  localparam logic REG_WALL_MASK = 1'b0;
  localparam logic REG_RAY_STEP  = 1'b1;

  localparam int RAYS        = 60;
  localparam int STEP_LIMIT  = 8;
  localparam int GRID        = 8;
  localparam int POS_SHIFT   = 12;
  localparam int STALL_LIMIT = 8000;
  localparam longint unsigned DEFAULT_MASK = 64'd18411262290262590975;

  // One expected ray result, in the field order of the result channel.
  typedef struct packed {
    logic [5:0]  ray_number;
    logic [14:0] hit_x;
    logic [14:0] hit_y;
    logic [15:0] range_q;
    logic        from_vertical;
    logic        found_wall;
    logic        last_ray;
  } ray_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_WALL_MASK;
  logic [63:0] cfg_data = '0;

  grc_in_if  in_ch ();
  grc_out_if out_ch ();

  grid_ray_caster uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always #4 clk = ~clk;

  // The predictor keeps its own copy of both registers.
  logic [63:0] wall_bits = DEFAULT_MASK;
  int unsigned ray_delta = 182;

  ray_result_t ray_queue[$];
  int          error_count = 0;
  int          idle_cycles = 0;

  // Receiver behavior: a percentage of stalled cycles, plus a long hold-off on request.
  int          stall_pct = 0;
  int          hold_cycles = 0;

  // Sender burst bookkeeping.
  int          burst_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.viewer_x = '0;
    in_ch.viewer_y = '0;
    in_ch.heading = '0;
    out_ch.ready = 1'b0;
  end

  const int atan_table[14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  // Direction vector (cos, sin) in Q1.14 from the shift-and-add rotation.
  task automatic heading_vector(input int unsigned ang, output int c, output int s);
    bit flip;
    int z, x, y, xs, ys;
    flip = (ang >= 16384 && ang < 49152);
    z = int'(ang);
    x = 9949;
    y = 0;
    if (flip) begin
      z -= 32768;
    end else if (z >= 32768) begin
      z -= 65536;
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_table[i];
      end else begin
        x += ys; y -= xs; z += atan_table[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic bit cell_is_wall(longint x, longint y);
    longint col, row, idx;
    if (x < 0 || y < 0) return 1'b0;
    col = x >>> POS_SHIFT;
    row = y >>> POS_SHIFT;
    if (col >= GRID || row >= GRID) return 1'b0;
    idx = row * GRID + col;
    // The origin cell never counts as a wall.
    if (idx == 0) return 1'b0;
    return wall_bits[idx];
  endfunction

  // Steps gridline crossings along coordinate a; b follows the slope num/den.
  task automatic gridline_walk(input longint pa, input longint pb, input bit fwd,
                               input int num, input int den, input bit a_is_x,
                               output bit hit, output longint ha, output longint hb);
    longint a, b, d, stride;
    a = fwd ? (((pa >>> POS_SHIFT) + 1) <<< POS_SHIFT) : (((pa >>> POS_SHIFT) <<< POS_SHIFT) - 1);
    stride = fwd ? (64'sd1 <<< POS_SHIFT) : -(64'sd1 <<< POS_SHIFT);
    d = (den < 0) ? -longint'(den) : longint'(den);
    if (d < 1) d = 1;
    if (!fwd) d = -d;
    hit = 1'b0;
    ha = 0;
    hb = 0;
    for (int k = 0; k < STEP_LIMIT && !hit; k++) begin
      b = pb + ((a - pa) * longint'(num)) / d;
      if (a_is_x ? cell_is_wall(a, b) : cell_is_wall(b, a)) begin
        hit = 1'b1; ha = a; hb = b;
      end
      a += stride;
    end
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Computes the whole sweep for one viewer and appends it to the expected rays.
  task automatic predict_sweep(input logic [14:0] vx, input logic [14:0] vy,
                               input logic [15:0] hd);
    int unsigned ang;
    int c, s;
    longint px, py, hx, hy, wx, wy, ox, oy;
    bit hh, vh, vert, found;
    longint unsigned dh, dv, dsel, rng;
    ray_result_t r;
    px = longint'(vx);
    py = longint'(vy);
    ang = (int'(hd) - (RAYS / 2) * ray_delta) & 32'hFFFF;
    for (int i = 0; i < RAYS; i++) begin
      heading_vector(ang, c, s);
      hh = 1'b0; vh = 1'b0; vert = 1'b0; found = 1'b0;
      hx = px; hy = py; wx = px; wy = py; ox = px; oy = py;
      dh = 0; dv = 0; dsel = 0; rng = 65535;
      // Rays along the x axis never cross a horizontal gridline, and vice versa.
      if (ang != 0 && ang != 32768)
        gridline_walk(py, px, ang < 32768, c, s, 1'b0, hh, hy, hx);
      if (ang != 16384 && ang != 49152)
        gridline_walk(px, py, !(ang > 16384 && ang < 49152), s, c, 1'b1, vh, wx, wy);
      if (hh) dh = longint'((hx - px) * (hx - px)) + longint'((hy - py) * (hy - py));
      if (vh) dv = longint'((wx - px) * (wx - px)) + longint'((wy - py) * (wy - py));
      // On equal distances the vertical hit wins.
      if (hh && (!vh || dh < dv)) begin
        ox = hx; oy = hy; dsel = dh; found = 1'b1;
      end else if (vh) begin
        ox = wx; oy = wy; dsel = dv; found = 1'b1; vert = 1'b1;
      end
      if (found) begin
        rng = int_sqrt(dsel);
        if (rng > 65535) rng = 65535;
      end
      r.ray_number = 6'(i);
      r.hit_x = 15'(ox);
      r.hit_y = 15'(oy);
      r.range_q = 16'(rng);
      r.from_vertical = vert;
      r.found_wall = found;
      r.last_ray = (i == RAYS - 1);
      ray_queue.push_back(r);
      ang = (ang + ray_delta) & 32'hFFFF;
    end
  endtask

  // Sends one viewer item; the sender works in bursts with random gaps between them.
  task automatic send_view(input logic [14:0] vx, input logic [14:0] vy, input logic [15:0] hd);
    if (burst_left == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 5);
    end
    burst_left--;
    in_ch.viewer_x = vx;
    in_ch.viewer_y = vy;
    in_ch.heading = hd;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_sweep(vx, vy, hd);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Waits until every expected ray has arrived and the block has settled.
  task automatic wait_drained();
    while (ray_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] value);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_WALL_MASK) wall_bits = value;
    else ray_delta = value[12:0];
  endtask

  function automatic logic [63:0] random_mask();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver: a random stall pattern, or a long hold-off counted down here.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Every result transfer is checked against the oldest expected ray.
  always @(posedge clk) begin
    ray_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ray_queue.size() == 0) begin
        $display("%0t: unexpected result, ray %0d", $time, out_ch.ray_number);
        error_count++;
      end else begin
        exp_r = ray_queue.pop_front();
        check_field("ray_number", exp_r.ray_number, out_ch.ray_number);
        check_field("hit_x", exp_r.hit_x, out_ch.hit_x);
        check_field("hit_y", exp_r.hit_y, out_ch.hit_y);
        check_field("range", exp_r.range_q, out_ch.range);
        check_field("from_vertical", exp_r.from_vertical, out_ch.from_vertical);
        check_field("found_wall", exp_r.found_wall, out_ch.found_wall);
        check_field("last_ray", exp_r.last_ray, out_ch.last_ray);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Reset map: the corners with axis-aligned headings and extreme positions, plus interior diagonal views.
  task automatic test_default_map();
    send_view(15'd0, 15'd0, 16'd0);
    send_view(15'h7FFF, 15'h7FFF, 16'd32768);
    send_view(15'h7FFF, 15'd0, 16'd16384);
    send_view(15'd0, 15'h7FFF, 16'd49152);
    send_view(15'h0800, 15'h0800, 16'd8192);
    send_view(15'h3800, 15'h4000, 16'hFFFF);
    send_view(15'h4000, 15'h4000, 16'd24576);
  endtask

  // Empty map gives only misses; a full map hits on the first crossing.
  task automatic test_map_extremes();
    write_reg(REG_WALL_MASK, 64'd0);
    write_reg(REG_RAY_STEP, 64'd4096);
    send_view(15'h4000, 15'h4000, 16'd0);
    send_view(15'h1234, 15'h6543, 16'd40000);
    write_reg(REG_WALL_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_RAY_STEP, 64'd1);
    send_view(15'h0800, 15'h0800, 16'd30);
    send_view(15'h4000, 15'h4000, 16'd16414);
    send_view(15'h7FFF, 15'h7FFF, 16'd32798);
    send_view(15'h0000, 15'h4000, 16'd49182);
    write_reg(REG_WALL_MASK, 64'h8000_0000_0000_0001);
    write_reg(REG_RAY_STEP, 64'd1092);
    send_view(15'h0100, 15'h0100, 16'd8192);
    send_view(15'h7F00, 15'h7F00, 16'd40960);
  endtask

  // Random maps, steps and viewers; the receiver stall rate changes per phase.
  task automatic test_random_views(input int count, input int stall);
    write_reg(REG_WALL_MASK, random_mask());
    write_reg(REG_RAY_STEP, 64'($urandom_range(1, 4096)));
    stall_pct = stall;
    repeat (count) begin
      send_view(15'($urandom()), 15'($urandom()), 16'($urandom()));
    end
  endtask

  // The receiver holds off while items keep coming, so the block stalls its input.
  task automatic test_backpressure();
    wait_drained();
    write_reg(REG_WALL_MASK, DEFAULT_MASK);
    write_reg(REG_RAY_STEP, 64'd182);
    stall_pct = 10;
    hold_cycles = 600;
    repeat (3) begin
      send_view(15'($urandom()), 15'($urandom()), 16'($urandom()));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_default_map();
    test_map_extremes();
    test_random_views(32, 0);
    test_random_views(32, 30);
    test_backpressure();
    test_random_views(32, 70);
    test_random_views(32, 15);
    wait_drained();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
